@@ sv/aes256_ctr_cipher_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef AES256_CTR_CIPHER_UNIT_DEFINES_SVH
`define AES256_CTR_CIPHER_UNIT_DEFINES_SVH
// Antecedent must imply consequent on the next edge.
`define ACU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
// Antecedent must imply consequent on the same edge.
`define ACU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/acu_pkg.sv @@
// Shared constants, tables and round functions for the AES-256 CTR unit.
package acu_pkg;
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumWords = 60;
  localparam int unsigned WordAw = 6;
  localparam int unsigned RoundW = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW = 64;
  localparam int unsigned InW = 136;
  localparam int unsigned OutW = 128;

  localparam logic [CfgIdxW-1:0] RegKey0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIv0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIv1 = 3'd5;

  localparam logic KindData = 1'b0;
  localparam logic KindReload = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8) modulo 0x11b.
  function automatic logic [7:0] gf_double(input logic [7:0] v);
    gf_double = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] v);
    sub_word = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // One cipher round without key addition; byte 4c+r sits in bits 8(4c+r)+7.
  function automatic logic [127:0] round_core(input logic [127:0] st, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = SBOX[st[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[8*(4*c) +: 8];
      a1 = t[8*(4*c+1) +: 8];
      a2 = t[8*(4*c+2) +: 8];
      a3 = t[8*(4*c+3) +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[8*(4*c) +: 8] = a0 ^ all ^ gf_double(a0 ^ a1);
      m[8*(4*c+1) +: 8] = a1 ^ all ^ gf_double(a1 ^ a2);
      m[8*(4*c+2) +: 8] = a2 ^ all ^ gf_double(a2 ^ a3);
      m[8*(4*c+3) +: 8] = a3 ^ all ^ gf_double(a3 ^ a0);
    end
    round_core = last ? t : m;
  endfunction
endpackage

@@ sv/aes256_ctr_cipher_unit.sv @@
// AES-256 counter-mode unit. A reload item (tuser high) closes the input while
// the 60 round-key words are written, one per cycle, into a 60x32 memory. The
// reload transfer also loads the counter from the IV registers. A reload gives
// no output. A data item with a nonzero byte count closes the input until its
// result is loaded; the single registered memory read port paces this. Each of
// the 15 key additions fetches its four round-key words through that port,
// issuing the first read before collecting any, then performs the round. A
// final step loads the output register and advances the counter. A byte count
// of zero passes the data through the output register without advancing the
// counter. Counts above 16 act as 16. A result that is not taken holds off the
// input, and holds off the end of a block that is still in flight.
module aes256_ctr_cipher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: data_low[63:0], data_high[127:64], byte_count[132:128], zero pad
  input  logic [135:0] s_axis_tdata,
  // tuser: kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_low[63:0], out_high[127:64]
  output logic [127:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  typedef enum logic [2:0] {IDLE, EXPAND, LOADKEY, ROUND, FINISH} state_t;

  state_t state;
  logic [63:0] key0, key1, key2, key3, iv0, iv1;
  logic [127:0] counter;
  logic [31:0] rk_mem [acu_pkg::NumWords];
  logic [31:0] rk_rdata;
  logic [acu_pkg::WordAw-1:0] rd_addr, wr_idx;
  logic [31:0] win [8];
  logic [7:0] rcon;
  logic [127:0] st, rkey, data;
  logic [4:0] count;
  logic [acu_pkg::RoundW-1:0] round;
  logic [1:0] wsel;
  logic rd_pend;

  // Expansion word from the sliding window of the last eight words.
  logic [31:0] prev, tmp, new_word;
  always_comb begin
    prev = win[7];
    if (wr_idx[2:0] == 3'd0) begin
      tmp = acu_pkg::sub_word({prev[7:0], prev[31:8]}) ^ {24'd0, rcon};
    end else if (wr_idx[2:0] == 3'd4) begin
      tmp = acu_pkg::sub_word(prev);
    end else begin
      tmp = prev;
    end
    new_word = (wr_idx < 6'd8) ? win[0] : (win[0] ^ tmp);
  end

  // Keystream byte mask and counter state in block byte order.
  logic [127:0] ctr_block, ks_mask;
  logic [4:0] cnt_eff;
  always_comb begin
    cnt_eff = (count > 5'd16) ? 5'd16 : count;
    for (int i = 0; i < 16; i++) begin
      ctr_block[8*i +: 8] = counter[8*(15-i) +: 8];
      ks_mask[8*i +: 8] = (5'(i) < cnt_eff) ? 8'hff : 8'h00;
    end
  end

  // Round-key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == EXPAND) begin
      rk_mem[wr_idx] <= new_word;
    end
    rk_rdata <= rk_mem[rd_addr];
  end

  assign s_axis_tready = (state == IDLE) && !(m_axis_tvalid && !m_axis_tready);

  // A new result enters the output register on this edge.
  logic out_load;
  assign out_load = ((state == IDLE) && s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser == acu_pkg::KindData) &&
                     (s_axis_tdata[132:128] == 5'd0)) ||
                    ((state == FINISH) && !(m_axis_tvalid && !m_axis_tready));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      key0 <= '0; key1 <= '0; key2 <= '0; key3 <= '0; iv0 <= '0; iv1 <= '0;
      counter <= '0;
      m_axis_tvalid <= 1'b0;
      rd_addr <= '0;
      wr_idx <= '0;
      round <= '0;
      wsel <= '0;
      rd_pend <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      // Take register writes.
      if (cfg_we) begin
        unique case (cfg_index)
          acu_pkg::RegKey0: key0 <= cfg_data;
          acu_pkg::RegKey1: key1 <= cfg_data;
          acu_pkg::RegKey2: key2 <= cfg_data;
          acu_pkg::RegKey3: key3 <= cfg_data;
          acu_pkg::RegIv0: iv0 <= cfg_data;
          acu_pkg::RegIv1: iv1 <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            data <= s_axis_tdata[127:0];
            count <= s_axis_tdata[132:128];
            if (s_axis_tuser == acu_pkg::KindReload) begin
              win <= '{key0[31:0], key0[63:32], key1[31:0], key1[63:32],
                       key2[31:0], key2[63:32], key3[31:0], key3[63:32]};
              rcon <= 8'h01;
              wr_idx <= '0;
              counter <= {iv0, iv1};
              state <= EXPAND;
            end else if (s_axis_tdata[132:128] == 5'd0) begin
              m_axis_tdata <= s_axis_tdata[127:0];
              m_axis_tvalid <= 1'b1;
            end else begin
              rd_addr <= '0;
              wsel <= '0;
              round <= '0;
              rd_pend <= 1'b0;
              state <= LOADKEY;
            end
          end
        end
        EXPAND: begin
          // First eight words come straight from the key; later words roll.
          if (wr_idx < 6'd8) begin
            win <= '{win[1], win[2], win[3], win[4], win[5], win[6], win[7], win[0]};
          end else begin
            win <= '{win[1], win[2], win[3], win[4], win[5], win[6], win[7], new_word};
            if (wr_idx[2:0] == 3'd0) begin
              rcon <= acu_pkg::gf_double(rcon);
            end
          end
          if (wr_idx == 6'(acu_pkg::NumWords - 1)) begin
            state <= IDLE;
          end
          wr_idx <= wr_idx + 6'd1;
        end
        LOADKEY: begin
          // Issue reads of four words; collect each word from the registered read data.
          if (rd_pend) begin
            rkey[32*wsel +: 32] <= rk_rdata;
            wsel <= wsel + 2'd1;
            if (wsel == 2'd3) begin
              state <= ROUND;
              rd_pend <= 1'b0;
            end
          end else begin
            rd_pend <= 1'b1;
          end
          if (!(rd_pend && wsel == 2'd3)) begin
            rd_addr <= rd_addr + 6'd1;
          end
        end
        ROUND: begin
          if (round == '0) begin
            st <= ctr_block ^ rkey;
          end else begin
            st <= acu_pkg::round_core(st, round == 4'(acu_pkg::NumRounds)) ^ rkey;
          end
          if (round == 4'(acu_pkg::NumRounds)) begin
            state <= FINISH;
          end else begin
            round <= round + 4'd1;
            wsel <= '0;
            state <= LOADKEY;
          end
        end
        FINISH: begin
          if (!(m_axis_tvalid && !m_axis_tready)) begin
            m_axis_tdata <= data ^ (st & ks_mask);
            m_axis_tvalid <= 1'b1;
            counter <= counter + 128'd1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ sv/acu_checker.sv @@
// Port-level checker for the AES-256 CTR unit, bound to the top level.
`include "aes256_ctr_cipher_unit_defines.svh"
module acu_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic s_axis_tuser,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  `ACU_ASSERT_NEXT(out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ACU_ASSERT_NEXT(data_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ACU_ASSERT_NEXT(reload_busy, clk, rst, in_xfer && s_axis_tuser, !s_axis_tready)
  `ACU_ASSERT_NEXT(reload_no_out, clk, rst, in_xfer && s_axis_tuser && !m_axis_tvalid,
                   !m_axis_tvalid)
endmodule

bind aes256_ctr_cipher_unit acu_checker u_acu_checker (.*);
